// ----- hw/rtl/scpbm_pkg.sv -----
package scpbm_pkg;

  localparam int unsigned VolumeChannels = 4;
  localparam int unsigned VolumePorts    = 4;

  typedef enum logic [2:0] {
    REQ_HOST_RD = 3'd0,
    REQ_HOST_WR = 3'd1,
    REQ_CP_RD   = 3'd2,
    REQ_CP_WR   = 3'd3,
    REQ_MEM     = 3'd4
  } req_t;

  localparam logic [7:0] PORT_HOST_CTRL = 8'h33;
  localparam logic [7:0] PORT_HOST_DATA = 8'hB3;
  localparam logic [7:0] PORT_HOST_CMD  = 8'hBB;

  localparam logic [7:0] PORT_CP_PAGE    = 8'h00;
  localparam logic [7:0] PORT_CP_CMD     = 8'h01;
  localparam logic [7:0] PORT_CP_DATA_IN = 8'h02;
  localparam logic [7:0] PORT_CP_DATA_OUT = 8'h03;
  localparam logic [7:0] PORT_CP_STATUS  = 8'h04;
  localparam logic [7:0] PORT_CP_CMD_CLR = 8'h05;
  localparam logic [7:0] PORT_CP_VOL0    = 8'h06;
  localparam logic [7:0] PORT_CP_LD_DATA = 8'h0A;
  localparam logic [7:0] PORT_CP_LD_CMD  = 8'h0B;
  localparam logic [7:0] PORT_CP_MODE    = 8'h0F;
  localparam logic [7:0] PORT_CP_UPPER   = 8'h10;
  localparam logic [7:0] PORT_CP_DMA_MODE = 8'h1B;
  localparam logic [7:0] PORT_CP_DMA_HI  = 8'h1C;
  localparam logic [7:0] PORT_CP_DMA_MID = 8'h1D;
  localparam logic [7:0] PORT_CP_DMA_LO  = 8'h1E;
  localparam logic [7:0] PORT_CP_DMA_CTL = 8'h1F;

  localparam int unsigned MODE_NOROM = 0;
  localparam int unsigned MODE_RAMRO = 1;
  localparam int unsigned MODE_EXPAG = 3;

  localparam logic [7:0] DMA_MODE_ON   = 8'd1;
  localparam logic [7:0] PAGE_MASK_RST = 8'h1F;
  localparam logic [7:0] UPPER_RST     = 8'h01;
  localparam logic [7:0] LOW_WIN_PAGE  = 8'h03;

  function automatic logic [7:0] rotl1(input logic [7:0] b);
    rotl1 = {b[6:0], b[7]};
  endfunction

endpackage

// ----- hw/rtl/sound_card_port_and_bank_mapper.sv -----
// The input word is held in the input register and then loaded into the result register, which drives the output.
// Throughput: one word per cycle; the input register and the result register
// each advance whenever the result register is empty or being taken.
// Reset: synchronous, active low; clears the valid flags and all card registers,
// sets the upper page to 1 and the page mask to 31.
module sound_card_port_and_bank_mapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // req_type
  input  logic [31:0] in_tdata,   // port, write_data, address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_data, cpu_reset, cpu_nmi, mem_from_rom,
                                  // mem_page, mem_offset, mem_write_ok, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic        s1_valid_r;
  logic [2:0]  s1_req_r;
  logic [7:0]  s1_port_r;
  logic [7:0]  s1_wdata_r;
  logic [15:0] s1_addr_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic [39:0] out_data_nxt;
  logic        advance;

  logic [7:0]  mask_r;
  logic [1:0]  flags_r, flags_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  to_cp_r, to_cp_nxt;
  logic [7:0]  from_cp_r, from_cp_nxt;
  logic [7:0]  main_r, main_nxt;
  logic [7:0]  upper_r, upper_nxt;
  logic [5:0]  mode_r, mode_nxt;
  logic [5:0]  vol_r [scpbm_pkg::VolumeChannels];
  logic [7:0]  dma_mode_r, dma_mode_nxt;
  logic [20:0] dma_addr_r, dma_addr_nxt;
  logic [7:0]  dma_ctl_r, dma_ctl_nxt;

  logic [7:0]  rd;
  logic        cpu_reset, cpu_nmi, rom, wok;
  logic [7:0]  page;
  logic [13:0] offset;
  logic [7:0]  rpage;
  logic        dma_on;
  logic        vol_wr;

  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;
  assign rpage      = scpbm_pkg::rotl1(s1_wdata_r) & mask_r;
  assign dma_on     = (dma_mode_r == scpbm_pkg::DMA_MODE_ON);
  assign vol_wr     = advance && (s1_req_r == scpbm_pkg::REQ_CP_WR);

  always_comb begin
    flags_nxt    = flags_r;
    cmd_nxt      = cmd_r;
    to_cp_nxt    = to_cp_r;
    from_cp_nxt  = from_cp_r;
    main_nxt     = main_r;
    upper_nxt    = upper_r;
    mode_nxt     = mode_r;
    dma_mode_nxt = dma_mode_r;
    dma_addr_nxt = dma_addr_r;
    dma_ctl_nxt  = dma_ctl_r;
    rd           = 8'h00;
    cpu_reset    = 1'b0;
    cpu_nmi      = 1'b0;
    rom          = 1'b0;
    wok          = 1'b0;
    page         = 8'h00;
    offset       = 14'd0;
    case (s1_req_r)
      scpbm_pkg::REQ_HOST_RD: begin
        case (s1_port_r)
          scpbm_pkg::PORT_HOST_DATA: begin
            flags_nxt[1] = 1'b0;
            rd = from_cp_r;
          end
          scpbm_pkg::PORT_HOST_CMD: rd = {flags_r[1], 6'h3F, flags_r[0]};
          default: rd = 8'hFF;
        endcase
      end
      scpbm_pkg::REQ_HOST_WR: begin
        case (s1_port_r)
          scpbm_pkg::PORT_HOST_CTRL: begin
            if (s1_wdata_r[7]) begin
              cpu_reset    = 1'b1;
              main_nxt     = 8'h00;
              upper_nxt    = scpbm_pkg::UPPER_RST;
              mode_nxt     = 6'h00;
              dma_mode_nxt = 8'h00;
              dma_addr_nxt = 21'd0;
              dma_ctl_nxt  = 8'h00;
            end else begin
              cpu_nmi = s1_wdata_r[6];
            end
          end
          scpbm_pkg::PORT_HOST_DATA: begin
            to_cp_nxt    = s1_wdata_r;
            flags_nxt[1] = 1'b1;
          end
          scpbm_pkg::PORT_HOST_CMD: begin
            cmd_nxt      = s1_wdata_r;
            flags_nxt[0] = 1'b1;
          end
          default: ;
        endcase
      end
      scpbm_pkg::REQ_CP_RD: begin
        case (s1_port_r)
          scpbm_pkg::PORT_CP_CMD: rd = cmd_r;
          scpbm_pkg::PORT_CP_DATA_IN: begin
            flags_nxt[1] = 1'b0;
            rd = to_cp_r;
          end
          scpbm_pkg::PORT_CP_DATA_OUT: begin
            flags_nxt[1] = 1'b1;
            from_cp_nxt  = 8'hFF;
            rd = 8'hFF;
          end
          scpbm_pkg::PORT_CP_STATUS: rd = {flags_r[1], 6'h00, flags_r[0]};
          scpbm_pkg::PORT_CP_CMD_CLR: begin
            flags_nxt[0] = 1'b0;
            rd = 8'hFF;
          end
          scpbm_pkg::PORT_CP_LD_DATA: begin
            flags_nxt[1] = main_r[0];
            rd = 8'hFF;
          end
          scpbm_pkg::PORT_CP_LD_CMD: begin
            flags_nxt[0] = vol_r[0][5];
            rd = 8'hFF;
          end
          scpbm_pkg::PORT_CP_MODE:     rd = {2'b00, mode_r};
          scpbm_pkg::PORT_CP_DMA_MODE: rd = dma_mode_r;
          scpbm_pkg::PORT_CP_DMA_HI:   rd = dma_on ? {3'b000, dma_addr_r[20:16]} : 8'hFF;
          scpbm_pkg::PORT_CP_DMA_MID:  rd = dma_on ? dma_addr_r[15:8] : 8'hFF;
          scpbm_pkg::PORT_CP_DMA_LO:   rd = dma_on ? dma_addr_r[7:0] : 8'hFF;
          scpbm_pkg::PORT_CP_DMA_CTL:  rd = dma_on ? dma_ctl_r : 8'hFF;
          default: rd = 8'hFF;
        endcase
      end
      scpbm_pkg::REQ_CP_WR: begin
        case (s1_port_r)
          scpbm_pkg::PORT_CP_PAGE: begin
            if (mode_r[scpbm_pkg::MODE_EXPAG]) begin
              main_nxt = rpage;
            end else begin
              main_nxt  = {rpage[7:1], 1'b0};
              upper_nxt = {rpage[7:1], 1'b1};
            end
          end
          scpbm_pkg::PORT_CP_DATA_IN:  flags_nxt[1] = 1'b0;
          scpbm_pkg::PORT_CP_DATA_OUT: begin
            flags_nxt[1] = 1'b1;
            from_cp_nxt  = s1_wdata_r;
          end
          scpbm_pkg::PORT_CP_CMD_CLR: flags_nxt[0] = 1'b0;
          scpbm_pkg::PORT_CP_LD_DATA: flags_nxt[1] = main_r[0];
          scpbm_pkg::PORT_CP_LD_CMD:  flags_nxt[0] = vol_r[0][5];
          scpbm_pkg::PORT_CP_MODE:    mode_nxt = s1_wdata_r[5:0];
          scpbm_pkg::PORT_CP_UPPER:   upper_nxt = rpage;
          scpbm_pkg::PORT_CP_DMA_MODE: dma_mode_nxt = s1_wdata_r;
          scpbm_pkg::PORT_CP_DMA_HI: begin
            if (dma_on) dma_addr_nxt[20:16] = s1_wdata_r[4:0];
          end
          scpbm_pkg::PORT_CP_DMA_MID: begin
            if (dma_on) dma_addr_nxt[15:8] = s1_wdata_r;
          end
          scpbm_pkg::PORT_CP_DMA_LO: begin
            if (dma_on) dma_addr_nxt[7:0] = s1_wdata_r;
          end
          scpbm_pkg::PORT_CP_DMA_CTL: begin
            if (dma_on) dma_ctl_nxt = s1_wdata_r;
          end
          default: ;
        endcase
      end
      scpbm_pkg::REQ_MEM: begin
        offset = s1_addr_r[13:0];
        if (mode_r[scpbm_pkg::MODE_NOROM]) begin
          case (s1_addr_r[15:14])
            2'd0: begin
              page = 8'h00;
              wok  = 1'b1;
            end
            2'd1: begin
              page = scpbm_pkg::LOW_WIN_PAGE;
              wok  = 1'b1;
            end
            2'd2: begin
              page = main_r;
              wok  = !(mode_r[scpbm_pkg::MODE_RAMRO] && (main_r[7:1] == 7'd0));
            end
            default: begin
              page = upper_r;
              wok  = !(mode_r[scpbm_pkg::MODE_RAMRO] && (upper_r[7:1] == 7'd0));
            end
          endcase
        end else begin
          case (s1_addr_r[15:14])
            2'd0: rom = 1'b1;
            2'd1: begin
              page = scpbm_pkg::LOW_WIN_PAGE;
              wok  = 1'b1;
            end
            2'd2: begin
              page = {3'b000, main_r[4:0]};
              rom  = 1'b1;
            end
            default: begin
              page = {3'b000, upper_r[4:0]};
              rom  = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
    out_data_nxt = {6'd0, wok, offset, page, rom, cpu_nmi, cpu_reset, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r   <= in_tuser;
      s1_port_r  <= in_tdata[7:0];
      s1_wdata_r <= in_tdata[15:8];
      s1_addr_r  <= in_tdata[31:16];
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r     <= scpbm_pkg::PAGE_MASK_RST;
      flags_r    <= 2'b00;
      cmd_r      <= 8'h00;
      to_cp_r    <= 8'h00;
      from_cp_r  <= 8'h00;
      main_r     <= 8'h00;
      upper_r    <= scpbm_pkg::UPPER_RST;
      mode_r     <= 6'h00;
      dma_mode_r <= 8'h00;
      dma_addr_r <= 21'd0;
      dma_ctl_r  <= 8'h00;
    end else begin
      if (cfg_valid) begin
        mask_r <= cfg_data;
      end
      if (advance) begin
        flags_r    <= flags_nxt;
        cmd_r      <= cmd_nxt;
        to_cp_r    <= to_cp_nxt;
        from_cp_r  <= from_cp_nxt;
        main_r     <= main_nxt;
        upper_r    <= upper_nxt;
        mode_r     <= mode_nxt;
        dma_mode_r <= dma_mode_nxt;
        dma_addr_r <= dma_addr_nxt;
        dma_ctl_r  <= dma_ctl_nxt;
      end
    end
  end

  for (genvar i = 0; i < scpbm_pkg::VolumeChannels; i++) begin : g_vol
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vol_r[i] <= 6'h00;
      end else if (vol_wr && (i < scpbm_pkg::VolumePorts) &&
                   (s1_port_r == scpbm_pkg::PORT_CP_VOL0 + 8'(i))) begin
        vol_r[i] <= s1_wdata_r[5:0];
      end
    end
  end

  a_reset_over_nmi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[8] |-> !out_data_r[9])
    else $error("reset and NMI raised together");

  a_ctrl_reset_maps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cpu_reset |=> (main_r == 8'h00) && (upper_r == scpbm_pkg::UPPER_RST) &&
                             (mode_r == 6'h00))
    else $error("control reset did not restore the mapping registers");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready && !advance)
    else $error("input taken while both stages are stalled");

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("an advanced word did not reach the result register");

endmodule

// ----- sim/sound_card_port_and_bank_mapper_tb.sv -----
`timescale 1ns / 100ps

module sound_card_port_and_bank_mapper_tb;

  localparam int FLAG_CMD = 0;
  localparam int FLAG_DATA = 1;
  localparam int VOL_PORTS = 4;
  localparam int PHASE_ITEMS = 360;
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam logic [7:0] MODE_ALL_ON = (8'd1 << scpbm_pkg::MODE_NOROM) |
                                       (8'd1 << scpbm_pkg::MODE_RAMRO) |
                                       (8'd1 << scpbm_pkg::MODE_EXPAG);

  typedef struct packed {
    logic [5:0]  pad;
    logic        write_ok;
    logic [13:0] offset;
    logic [7:0]  page;
    logic        from_rom;
    logic        nmi;
    logic        cpu_rst;
    logic [7:0]  rd_data;
  } reply_t;

  class card_shadow;
    logic [7:0]  page_mask;
    logic [1:0]  flags;
    logic [7:0]  cmd_latch, to_cp, from_cp, main_pg, upper_pg;
    logic [5:0]  mode;
    logic [5:0]  vol [scpbm_pkg::VolumeChannels];
    logic [7:0]  dma_md, dma_ctl;
    logic [20:0] dma_adr;
    reply_t      pending_replies[$];
    int          mismatches;

    function new();
      page_mask = scpbm_pkg::PAGE_MASK_RST;
      flags = '0;
      cmd_latch = '0;
      to_cp = '0;
      from_cp = '0;
      foreach (vol[i]) vol[i] = '0;
      mismatches = 0;
      clear_mapping();
    endfunction

    function void clear_mapping();
      main_pg = '0;
      upper_pg = scpbm_pkg::UPPER_RST;
      mode = '0;
      dma_md = '0;
      dma_adr = '0;
      dma_ctl = '0;
    endfunction

    function void take_access(logic [2:0] req, logic [7:0] p, logic [7:0] v,
                              logic [15:0] a);
      reply_t r;
      logic [7:0] pg;
      logic [7:0] sel;
      logic dma_ok;
      int ch;
      r = '0;
      pg = {v[6:0], v[7]} & page_mask;
      dma_ok = (dma_md == scpbm_pkg::DMA_MODE_ON);
      case (req)
        scpbm_pkg::REQ_HOST_RD: begin
          if (p == scpbm_pkg::PORT_HOST_DATA) begin
            flags[FLAG_DATA] = 1'b0;
            r.rd_data = from_cp;
          end else if (p == scpbm_pkg::PORT_HOST_CMD) begin
            r.rd_data = {flags[FLAG_DATA], 6'h3F, flags[FLAG_CMD]};
          end else begin
            r.rd_data = 8'hFF;
          end
        end
        scpbm_pkg::REQ_HOST_WR: begin
          if (p == scpbm_pkg::PORT_HOST_CTRL) begin
            if (v[7]) begin
              clear_mapping();
              r.cpu_rst = 1'b1;
            end else if (v[6]) begin
              r.nmi = 1'b1;
            end
          end else if (p == scpbm_pkg::PORT_HOST_DATA) begin
            to_cp = v;
            flags[FLAG_DATA] = 1'b1;
          end else if (p == scpbm_pkg::PORT_HOST_CMD) begin
            cmd_latch = v;
            flags[FLAG_CMD] = 1'b1;
          end
        end
        scpbm_pkg::REQ_CP_RD: begin
          r.rd_data = 8'hFF;
          case (p)
            scpbm_pkg::PORT_CP_CMD: r.rd_data = cmd_latch;
            scpbm_pkg::PORT_CP_DATA_IN: begin
              flags[FLAG_DATA] = 1'b0;
              r.rd_data = to_cp;
            end
            scpbm_pkg::PORT_CP_DATA_OUT: begin
              flags[FLAG_DATA] = 1'b1;
              from_cp = 8'hFF;
            end
            scpbm_pkg::PORT_CP_STATUS:
              r.rd_data = {flags[FLAG_DATA], 6'd0, flags[FLAG_CMD]};
            scpbm_pkg::PORT_CP_CMD_CLR: flags[FLAG_CMD] = 1'b0;
            scpbm_pkg::PORT_CP_LD_DATA: flags[FLAG_DATA] = main_pg[0];
            scpbm_pkg::PORT_CP_LD_CMD: flags[FLAG_CMD] = vol[0][5];
            scpbm_pkg::PORT_CP_MODE: r.rd_data = {2'b00, mode};
            scpbm_pkg::PORT_CP_DMA_MODE: r.rd_data = dma_md;
            scpbm_pkg::PORT_CP_DMA_HI: if (dma_ok) r.rd_data = {3'b000, dma_adr[20:16]};
            scpbm_pkg::PORT_CP_DMA_MID: if (dma_ok) r.rd_data = dma_adr[15:8];
            scpbm_pkg::PORT_CP_DMA_LO: if (dma_ok) r.rd_data = dma_adr[7:0];
            scpbm_pkg::PORT_CP_DMA_CTL: if (dma_ok) r.rd_data = dma_ctl;
            default: ;
          endcase
        end
        scpbm_pkg::REQ_CP_WR: begin
          case (p)
            scpbm_pkg::PORT_CP_PAGE: begin
              if (mode[scpbm_pkg::MODE_EXPAG]) begin
                main_pg = pg;
              end else begin
                main_pg = pg & 8'hFE;
                upper_pg = pg | 8'h01;
              end
            end
            scpbm_pkg::PORT_CP_DATA_IN: flags[FLAG_DATA] = 1'b0;
            scpbm_pkg::PORT_CP_DATA_OUT: begin
              flags[FLAG_DATA] = 1'b1;
              from_cp = v;
            end
            scpbm_pkg::PORT_CP_CMD_CLR: flags[FLAG_CMD] = 1'b0;
            scpbm_pkg::PORT_CP_LD_DATA: flags[FLAG_DATA] = main_pg[0];
            scpbm_pkg::PORT_CP_LD_CMD: flags[FLAG_CMD] = vol[0][5];
            scpbm_pkg::PORT_CP_MODE: mode = v[5:0];
            scpbm_pkg::PORT_CP_UPPER: upper_pg = pg;
            scpbm_pkg::PORT_CP_DMA_MODE: dma_md = v;
            scpbm_pkg::PORT_CP_DMA_HI: if (dma_ok) dma_adr[20:16] = v[4:0];
            scpbm_pkg::PORT_CP_DMA_MID: if (dma_ok) dma_adr[15:8] = v;
            scpbm_pkg::PORT_CP_DMA_LO: if (dma_ok) dma_adr[7:0] = v;
            scpbm_pkg::PORT_CP_DMA_CTL: if (dma_ok) dma_ctl = v;
            default: begin
              ch = int'(p) - int'(scpbm_pkg::PORT_CP_VOL0);
              if (ch >= 0 && ch < VOL_PORTS && ch < scpbm_pkg::VolumeChannels)
                vol[ch] = v[5:0];
            end
          endcase
        end
        scpbm_pkg::REQ_MEM: begin
          r.offset = a[13:0];
          sel = a[14] ? upper_pg : main_pg;
          case (a[15:14])
            2'd0: begin
              r.from_rom = ~mode[scpbm_pkg::MODE_NOROM];
              r.write_ok = mode[scpbm_pkg::MODE_NOROM];
            end
            2'd1: begin
              r.page = scpbm_pkg::LOW_WIN_PAGE;
              r.write_ok = 1'b1;
            end
            default: begin
              if (mode[scpbm_pkg::MODE_NOROM]) begin
                r.page = sel;
                r.write_ok = !(mode[scpbm_pkg::MODE_RAMRO] && sel <= 8'd1);
              end else begin
                r.page = sel & 8'h1F;
                r.from_rom = 1'b1;
              end
            end
          endcase
        end
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(logic [39:0] word);
      reply_t got, want;
      got = reply_t'(word);
      if (pending_replies.size() == 0) begin
        $error("output word %h arrived with no access awaiting it", word);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        compare_field("read_data", 16'(want.rd_data), 16'(got.rd_data));
        compare_field("cpu_reset", 16'(want.cpu_rst), 16'(got.cpu_rst));
        compare_field("cpu_nmi", 16'(want.nmi), 16'(got.nmi));
        compare_field("mem_from_rom", 16'(want.from_rom), 16'(got.from_rom));
        compare_field("mem_page", 16'(want.page), 16'(got.page));
        compare_field("mem_offset", 16'(want.offset), 16'(got.offset));
        compare_field("mem_write_ok", 16'(want.write_ok), 16'(got.write_ok));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  card_shadow shadow;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  sound_card_port_and_bank_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // The receiver picks one of four stall behaviours at random and moves to a new one when its countdown runs out.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_reply(out_tdata);
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((stall_left % 8) < 3);
    endcase
  end

  task automatic send_access(input logic [2:0] req, input logic [7:0] p, input logic [7:0] v,
                             input logic [15:0] a);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {a, v, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.take_access(req, p, v, a);
  endtask

  task automatic random_access();
    logic [2:0] req;
    logic [7:0] p, v;
    logic [15:0] a;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) req = scpbm_pkg::REQ_HOST_RD;
    else if (pick < 26) req = scpbm_pkg::REQ_HOST_WR;
    else if (pick < 44) req = scpbm_pkg::REQ_CP_RD;
    else if (pick < 72) req = scpbm_pkg::REQ_CP_WR;
    else if (pick < 97) req = scpbm_pkg::REQ_MEM;
    else req = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    v = 8'($urandom);
    a = 16'($urandom);
    if (req == scpbm_pkg::REQ_HOST_RD || req == scpbm_pkg::REQ_HOST_WR) begin
      case ($urandom_range(0, 3))
        0: p = scpbm_pkg::PORT_HOST_CTRL;
        1: p = scpbm_pkg::PORT_HOST_DATA;
        2: p = scpbm_pkg::PORT_HOST_CMD;
        default: p = 8'($urandom);
      endcase
    end else if ($urandom_range(0, 99) < 85) begin
      p = 8'($urandom_range(0, 8'h20));
    end else begin
      p = 8'($urandom);
    end
    // A control-port reset wipes the mapping, so keep it fairly rare.
    if (req == scpbm_pkg::REQ_HOST_WR && p == scpbm_pkg::PORT_HOST_CTRL &&
        $urandom_range(0, 3) != 0) v[7] = 1'b0;
    if (req == scpbm_pkg::REQ_CP_WR && p == scpbm_pkg::PORT_CP_DMA_MODE &&
        $urandom_range(0, 1) == 0)
      v = scpbm_pkg::DMA_MODE_ON;
    send_access(req, p, v, a);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (shadow.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_page_mask(input logic [7:0] m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow.page_mask = m;
  endtask

  initial begin
    logic [7:0] masks [4];
    shadow = new();
    masks[0] = 8'hFF;
    masks[1] = 8'h00;
    masks[2] = 8'($urandom);
    masks[3] = 8'h07;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_access(scpbm_pkg::REQ_HOST_RD, scpbm_pkg::PORT_HOST_CMD, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_HOST_RD, 8'hFF, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_HOST_WR, scpbm_pkg::PORT_HOST_CMD, 8'hFF, 16'h0000);
    send_access(scpbm_pkg::REQ_HOST_WR, scpbm_pkg::PORT_HOST_DATA, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_RD, scpbm_pkg::PORT_CP_STATUS, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_RD, scpbm_pkg::PORT_CP_CMD, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_RD, scpbm_pkg::PORT_CP_DATA_IN, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_WR, scpbm_pkg::PORT_CP_CMD_CLR, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_WR, scpbm_pkg::PORT_CP_DATA_OUT, 8'hA5, 16'h0000);
    send_access(scpbm_pkg::REQ_HOST_RD, scpbm_pkg::PORT_HOST_DATA, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_RD, scpbm_pkg::PORT_CP_DATA_OUT, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_WR, scpbm_pkg::PORT_CP_VOL0, 8'hFF, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_WR, scpbm_pkg::PORT_CP_VOL0 + 8'd3, 8'h15, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_RD, scpbm_pkg::PORT_CP_LD_CMD, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_RD, scpbm_pkg::PORT_CP_DMA_HI, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_WR, scpbm_pkg::PORT_CP_DMA_MODE, scpbm_pkg::DMA_MODE_ON,
                16'h0000);
    send_access(scpbm_pkg::REQ_CP_WR, scpbm_pkg::PORT_CP_DMA_HI, 8'hFF, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_RD, scpbm_pkg::PORT_CP_DMA_HI, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_WR, scpbm_pkg::PORT_CP_PAGE, 8'hFF, 16'h0000);
    send_access(scpbm_pkg::REQ_MEM, 8'h00, 8'h00, 16'hFFFF);
    send_access(scpbm_pkg::REQ_CP_WR, scpbm_pkg::PORT_CP_MODE, MODE_ALL_ON, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_WR, scpbm_pkg::PORT_CP_PAGE, 8'h00, 16'h0000);
    send_access(scpbm_pkg::REQ_MEM, 8'h00, 8'h00, 16'hBFFF);
    send_access(scpbm_pkg::REQ_MEM, 8'h00, 8'h00, 16'h4000);
    send_access(scpbm_pkg::REQ_HOST_WR, scpbm_pkg::PORT_HOST_CTRL, 8'hC0, 16'h0000);
    send_access(scpbm_pkg::REQ_HOST_WR, scpbm_pkg::PORT_HOST_CTRL, 8'h40, 16'h0000);
    send_access(scpbm_pkg::REQ_CP_RD, scpbm_pkg::PORT_CP_MODE, 8'h00, 16'h0000);
    send_access(REQ_SPARE_HI, 8'hFF, 8'hFF, 16'hFFFF);

    repeat (PHASE_ITEMS) random_access();
    foreach (masks[i]) begin
      wait_idle();
      write_page_mask(masks[i]);
      repeat (PHASE_ITEMS) random_access();
    end
    wait_idle();
    repeat (6) @(posedge clk);

    if (shadow.mismatches == 0 && shadow.pending_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/scpbm_pkg.sv
hw/rtl/sound_card_port_and_bank_mapper.sv
sim/sound_card_port_and_bank_mapper_tb.sv
